FILE: rtl/core/tlaik_pkg.sv
// ----------------------------------------------------------------------------
// tlaik_pkg
// Shared types, codes and constants of the two-link arm inverse kinematics unit.
// ----------------------------------------------------------------------------
package tlaik_pkg;

    // default parameter values
    localparam int FRAC_BITS_DEF     = 12;
    localparam int CORDIC_STAGES_DEF = 14;

    // cordic working widths
    localparam int CW             = 44;
    localparam int ZW             = 33;
    localparam int TAB_LEN        = 24;
    localparam int NORM_STEPS     = 6;
    localparam int NORM_LIMIT_LOG = 40;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNREACH = 2'd1;
    localparam logic [1:0] ST_DIV0    = 2'd2;

    // register indexes
    localparam logic [1:0] CFG_UPPER = 2'd0;
    localparam logic [1:0] CFG_LOWER = 2'd1;
    localparam logic [1:0] CFG_FLIP  = 2'd2;

    typedef struct packed {
        logic signed [15:0] reach_distance;
        logic signed [15:0] target_height;
    } tlaik_in_t;

    typedef struct packed {
        logic signed [15:0] shoulder_angle;
        logic signed [15:0] elbow_angle;
        logic [1:0]         status;
    } tlaik_out_t;

    // per-word side data that travels down the pipe
    typedef struct packed {
        logic signed [15:0] dd;
        logic signed [15:0] hh;
        logic [1:0]         status;
        logic               neg;
    } tlaik_side_t;

    // arctangent of 2^-idx with 30 fraction bits
    function automatic logic [31:0] atan_entry(input int idx);
        logic [31:0] val;
        unique case (idx)
            0:       val = 32'd843314856;
            1:       val = 32'd497837829;
            2:       val = 32'd263043836;
            3:       val = 32'd133525158;
            4:       val = 32'd67021686;
            5:       val = 32'd33543515;
            6:       val = 32'd16775850;
            7:       val = 32'd8388437;
            8:       val = 32'd4194282;
            9:       val = 32'd2097149;
            10:      val = 32'd1048575;
            11:      val = 32'd524287;
            12:      val = 32'd262143;
            13:      val = 32'd131071;
            14:      val = 32'd65535;
            15:      val = 32'd32767;
            16:      val = 32'd16383;
            17:      val = 32'd8191;
            18:      val = 32'd4095;
            19:      val = 32'd2047;
            20:      val = 32'd1023;
            21:      val = 32'd511;
            22:      val = 32'd255;
            23:      val = 32'd127;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

FILE: rtl/core/two_link_arm_inverse_kinematics_unit.sv
// ----------------------------------------------------------------------------
// two_link_arm_inverse_kinematics_unit
// Shoulder and elbow angles of a two-link planar arm from target reach and height.
// ----------------------------------------------------------------------------
// throughput: one word per cycle; busy stays low
// latency is set by the bit-per-stage divider and square root and the cordic stages
// results show on result for one cycle with done; the receiver cannot stall
// reset clears all valid bits and loads the link and threshold registers with defaults
module two_link_arm_inverse_kinematics_unit
    import tlaik_pkg::*;
#(
    parameter int FRAC_BITS     = FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  tlaik_in_t   target,
    output logic        done,
    output tlaik_out_t  result,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int ONE       = 1 << FRAC_BITS;
    localparam int L_RESET   = (4 * ONE + 2) / 5;
    localparam int THR_RESET = -((7 * ONE + 10) / 20);
    localparam int XW        = 15 + FRAC_BITS + 2;
    localparam int CL        = NORM_STEPS + 1 + CORDIC_STAGES;
    localparam int AW        = ZW + 2;
    localparam int LAT       = 2 * FRAC_BITS + 7 + CL;
    localparam logic [2*FRAC_BITS+1:0] ONE_SQ = (2*FRAC_BITS+2)'(1) << (2 * FRAC_BITS);

    // configuration registers
    logic [14:0]        l1_reg;
    logic [14:0]        l2_reg;
    logic signed [15:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_reg  <= 15'(L_RESET);
            l2_reg  <= 15'(L_RESET);
            thr_reg <= 16'(THR_RESET);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_UPPER: l1_reg  <= cfg_data[14:0];
                CFG_LOWER: l2_reg  <= cfg_data[14:0];
                CFG_FLIP:  thr_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    assign busy = 1'b0;

    // link products: user keeps them held steady while words are in flight, unenforced
    logic [29:0] l1sq_reg;
    logic [29:0] l2sq_reg;
    logic [31:0] den_reg;

    always_ff @(posedge clk)
    begin
        l1sq_reg  <= 30'(l1_reg) * 30'(l1_reg);
        l2sq_reg  <= 30'(l2_reg) * 30'(l2_reg);
        den_reg   <= {1'b0, 30'(l1_reg) * 30'(l2_reg), 1'b0};
    end

    // stage 1: squares of the target coordinates
    logic               s1_valid_reg;
    logic signed [15:0] s1_dd_reg;
    logic signed [15:0] s1_hh_reg;
    logic signed [31:0] s1_dsq_reg;
    logic signed [31:0] s1_hsq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_dd_reg  <= target.reach_distance;
        s1_hh_reg  <= target.target_height;
        s1_dsq_reg <= 32'(target.reach_distance) * 32'(target.reach_distance);
        s1_hsq_reg <= 32'(target.target_height) * 32'(target.target_height);
    end

    // stage 2: numerator, range checks
    logic signed [33:0] num_next;
    logic [32:0]        anum_next;
    tlaik_side_t        s2_side_next;
    logic               s2_valid_reg;
    tlaik_side_t        s2_side_reg;
    logic [32:0]        s2_anum_reg;

    always_comb
    begin
        num_next  = 34'(s1_dsq_reg) + 34'(s1_hsq_reg)
                    - $signed({4'd0, l1sq_reg}) - $signed({4'd0, l2sq_reg});
        anum_next = num_next[33] ? 33'(-num_next) : num_next[32:0];
        s2_side_next.dd  = s1_dd_reg;
        s2_side_next.hh  = s1_hh_reg;
        s2_side_next.neg = num_next[33];
        priority if (den_reg == '0 || s1_dd_reg == '0)
            s2_side_next.status = ST_DIV0;
        else if (anum_next > {1'b0, den_reg})
            s2_side_next.status = ST_UNREACH;
        else if (num_next == '0)
            s2_side_next.status = ST_DIV0;
        else
            s2_side_next.status = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_side_reg <= s2_side_next;
        s2_anum_reg <= anum_next;
    end

    // |d| with FRAC_BITS fraction bits
    logic               dv_valid;
    tlaik_side_t        dv_side;
    logic [FRAC_BITS:0] dv_quot;

    tlaik_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .in_side   (s2_side_reg),
        .in_num    (s2_anum_reg),
        .den       (den_reg),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_quot  (dv_quot)
    );

    // stage 3: radicand 1 - d^2
    logic                 s3_valid_reg;
    tlaik_side_t          s3_side_reg;
    logic [FRAC_BITS:0]   s3_adq_reg;
    logic [2*FRAC_BITS:0] s3_rad_reg;
    logic [2*FRAC_BITS+1:0] dsq_next;

    assign dsq_next = (2*FRAC_BITS+2)'(dv_quot) * (2*FRAC_BITS+2)'(dv_quot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_side_reg <= dv_side;
        s3_adq_reg  <= dv_quot;
        s3_rad_reg  <= (2*FRAC_BITS+1)'(ONE_SQ - dsq_next);
    end

    logic               sq_valid;
    tlaik_side_t        sq_side;
    logic [FRAC_BITS:0] sq_adq;
    logic [FRAC_BITS:0] sq_root;

    tlaik_sqrt #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .in_side   (s3_side_reg),
        .in_adq    (s3_adq_reg),
        .in_rad    (s3_rad_reg),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .out_adq   (sq_adq),
        .out_root  (sq_root)
    );

    // stage 4: cordic operands for the three angles
    logic [XW-1:0]        xr_next;
    logic [XW-1:0]        yr_next;
    tlaik_side_t          s4_side_next;
    logic                 s4_valid_reg;
    tlaik_side_t          s4_side_reg;
    logic signed [CW-1:0] t3x_reg;
    logic signed [CW-1:0] t3y_reg;
    logic signed [CW-1:0] a2x_reg;
    logic signed [CW-1:0] a2y_reg;
    logic signed [CW-1:0] a1x_reg;
    logic signed [CW-1:0] a1y_reg;

    always_comb
    begin
        xr_next = (XW'(l1_reg) << FRAC_BITS) + XW'(l2_reg) * XW'(sq_adq);
        yr_next = XW'(l2_reg) * XW'(sq_root);
        s4_side_next = sq_side;
        if (sq_side.status == ST_OK && xr_next == '0)
        begin
            s4_side_next.status = ST_DIV0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_side_reg <= s4_side_next;
        t3x_reg     <= $signed(CW'(sq_adq));
        t3y_reg     <= $signed(CW'(sq_root));
        a2x_reg     <= $signed(CW'(xr_next));
        a2y_reg     <= sq_side.neg ? -$signed(CW'(yr_next)) : $signed(CW'(yr_next));
        a1x_reg     <= sq_side.dd[15] ? -CW'(sq_side.dd) : CW'(sq_side.dd);
        a1y_reg     <= sq_side.dd[15] ? -CW'(sq_side.hh) : CW'(sq_side.hh);
    end

    // three angle pipelines in parallel
    logic                 t3_valid;
    logic                 a2_valid;
    logic                 a1_valid;
    logic signed [ZW-1:0] t3_z;
    logic signed [ZW-1:0] a2_z;
    logic signed [ZW-1:0] a1_z;

    tlaik_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic_elbow (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_valid_reg),
        .in_x      (t3x_reg),
        .in_y      (t3y_reg),
        .out_valid (t3_valid),
        .out_angle (t3_z)
    );

    tlaik_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic_link (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_valid_reg),
        .in_x      (a2x_reg),
        .in_y      (a2y_reg),
        .out_valid (a2_valid),
        .out_angle (a2_z)
    );

    tlaik_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic_target (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_valid_reg),
        .in_x      (a1x_reg),
        .in_y      (a1y_reg),
        .out_valid (a1_valid),
        .out_angle (a1_z)
    );

    // side data delay line matching the cordic depth
    tlaik_side_t dly_side_reg [CL];

    genvar j;
    for (j = 0; j < CL; j++)
    begin : g_dly
        if (j == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                dly_side_reg[j] <= s4_side_reg;
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                dly_side_reg[j] <= dly_side_reg[j-1];
            end
        end
    end

    // round the 30-bit-fraction angle to FRAC_BITS, half up
    function automatic logic signed [AW-1:0] round_angle(input logic signed [ZW-1:0] z);
        logic signed [AW-1:0] sum;
        sum = AW'(z) + (AW'(1) <<< (29 - FRAC_BITS));
        return sum >>> (30 - FRAC_BITS);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [AW-1:0] v);
        logic signed [15:0] res;
        priority if (v > AW'(32767))
            res = 16'sd32767;
        else if (v < -AW'(32768))
            res = -16'sd32768;
        else
            res = v[15:0];
        return res;
    endfunction

    // final stage: combine angles, pose choice, saturation, zero angles on error words
    logic signed [AW-1:0] c3;
    logic signed [AW-1:0] t3;
    logic signed [AW-1:0] t2;
    logic signed [AW-1:0] t3o;
    tlaik_side_t          fin_side;
    tlaik_out_t           result_next;
    logic                 done_reg;
    tlaik_out_t           result_reg;

    always_comb
    begin
        fin_side = dly_side_reg[CL-1];
        c3       = round_angle(t3_z);
        t3       = fin_side.neg ? -c3 : c3;
        t2       = round_angle(a2_z) - round_angle(a1_z);
        t3o      = -t3;
        if (t2 > AW'(thr_reg))
        begin
            t2  = t2 + t3o;
            t3o = t3;
        end
        if (fin_side.status == ST_OK)
        begin
            result_next.shoulder_angle = sat16(t2);
            result_next.elbow_angle    = sat16(t3o);
        end
        else
        begin
            result_next.shoulder_angle = '0;
            result_next.elbow_angle    = '0;
        end
        result_next.status = fin_side.status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= t3_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // the three angle pipelines stay in lockstep
    a_cordic_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (t3_valid == a2_valid) && (t3_valid == a1_valid))
        else $error("angle pipelines out of step");

    // every accepted word comes out on done
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result word missing at expected latency");

    // error words carry zero angles
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |->
        (result.shoulder_angle == '0 && result.elbow_angle == '0))
        else $error("nonzero angle on error word");

    // status is one of the defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == ST_OK || result.status == ST_UNREACH ||
                  result.status == ST_DIV0))
        else $error("undefined status code");

endmodule

FILE: rtl/core/tlaik_divider.sv
// ----------------------------------------------------------------------------
// tlaik_divider
// Pipelined restoring divider: floor(num * 2^FRAC_BITS / den), one bit a stage.
// ----------------------------------------------------------------------------
module tlaik_divider
    import tlaik_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  tlaik_side_t          in_side,
    input  logic [32:0]          in_num,
    input  logic [31:0]          den,
    output logic                 out_valid,
    output tlaik_side_t          out_side,
    output logic [FRAC_BITS:0]   out_quot
);

    localparam int NS = FRAC_BITS + 1;

    logic                valid_reg [NS];
    tlaik_side_t         side_reg  [NS];
    logic [32:0]         rem_reg   [NS];
    logic [FRAC_BITS:0]  quot_reg  [NS];

    genvar k;
    for (k = 0; k < NS; k++)
    begin : g_stage
        logic               valid_in;
        tlaik_side_t        side_in;
        logic [32:0]        rem_in;
        logic [FRAC_BITS:0] quot_in;
        logic               take;
        logic [32:0]        rem_next;
        logic [FRAC_BITS:0] quot_next;

        // first stage takes the numerator, later ones the doubled remainder
        if (k == 0)
        begin : g_first
            assign valid_in = in_valid;
            assign side_in  = in_side;
            assign rem_in   = in_num;
            assign quot_in  = '0;
        end
        else
        begin : g_next
            assign valid_in = valid_reg[k-1];
            assign side_in  = side_reg[k-1];
            assign rem_in   = {rem_reg[k-1][31:0], 1'b0};
            assign quot_in  = quot_reg[k-1];
        end

        // compare and subtract
        always_comb
        begin
            take      = (rem_in >= {1'b0, den});
            rem_next  = take ? (rem_in - {1'b0, den}) : rem_in;
            quot_next = quot_in;
            quot_next[FRAC_BITS-k] = take;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            side_reg[k] <= side_in;
            rem_reg[k]  <= rem_next;
            quot_reg[k] <= quot_next;
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_side  = side_reg[NS-1];
    assign out_quot  = quot_reg[NS-1];

endmodule

FILE: rtl/core/tlaik_sqrt.sv
// ----------------------------------------------------------------------------
// tlaik_sqrt
// Pipelined floor integer square root, one result bit a stage.
// ----------------------------------------------------------------------------
module tlaik_sqrt
    import tlaik_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  tlaik_side_t          in_side,
    input  logic [FRAC_BITS:0]   in_adq,
    input  logic [2*FRAC_BITS:0] in_rad,
    output logic                 out_valid,
    output tlaik_side_t          out_side,
    output logic [FRAC_BITS:0]   out_adq,
    output logic [FRAC_BITS:0]   out_root
);

    localparam int NS = FRAC_BITS + 1;
    localparam int RW = 2 * FRAC_BITS + 2;

    logic                valid_reg [NS];
    tlaik_side_t         side_reg  [NS];
    logic [FRAC_BITS:0]  adq_reg   [NS];
    logic [RW-1:0]       rem_reg   [NS];
    logic [FRAC_BITS:0]  root_reg  [NS];

    genvar k;
    for (k = 0; k < NS; k++)
    begin : g_stage
        localparam int B = FRAC_BITS - k;
        logic               valid_in;
        tlaik_side_t        side_in;
        logic [FRAC_BITS:0] adq_in;
        logic [RW-1:0]      rem_in;
        logic [FRAC_BITS:0] root_in;
        logic [RW-1:0]      trial;
        logic               take;
        logic [RW-1:0]      rem_next;
        logic [FRAC_BITS:0] root_next;

        if (k == 0)
        begin : g_first
            assign valid_in = in_valid;
            assign side_in  = in_side;
            assign adq_in   = in_adq;
            assign rem_in   = RW'(in_rad);
            assign root_in  = '0;
        end
        else
        begin : g_next
            assign valid_in = valid_reg[k-1];
            assign side_in  = side_reg[k-1];
            assign adq_in   = adq_reg[k-1];
            assign rem_in   = rem_reg[k-1];
            assign root_in  = root_reg[k-1];
        end

        // try setting bit B: needs 2*root*2^B + 4^B out of the remainder
        always_comb
        begin
            trial     = (RW'(root_in) << (B + 1)) + (RW'(1) << (2 * B));
            take      = (rem_in >= trial);
            rem_next  = take ? (rem_in - trial) : rem_in;
            root_next = root_in;
            root_next[B] = take;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            side_reg[k] <= side_in;
            adq_reg[k]  <= adq_in;
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_side  = side_reg[NS-1];
    assign out_adq   = adq_reg[NS-1];
    assign out_root  = root_reg[NS-1];

endmodule

FILE: rtl/core/tlaik_cordic.sv
// ----------------------------------------------------------------------------
// tlaik_cordic
// Pipelined vectoring cordic: normalizing shift stages, then one rotation a stage.
// ----------------------------------------------------------------------------
module tlaik_cordic
    import tlaik_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] in_x,
    input  logic signed [CW-1:0] in_y,
    output logic                 out_valid,
    output logic signed [ZW-1:0] out_angle
);

    localparam int NN = NORM_STEPS + 1;
    localparam int NS = NN + CORDIC_STAGES;

    logic                 valid_reg [NS];
    logic signed [CW-1:0] x_reg     [NS];
    logic signed [CW-1:0] y_reg     [NS];
    logic signed [ZW-1:0] z_reg     [NS];

    genvar k;
    for (k = 0; k < NS; k++)
    begin : g_stage
        logic                 valid_in;
        logic signed [CW-1:0] x_in;
        logic signed [CW-1:0] y_in;
        logic signed [ZW-1:0] z_in;
        logic signed [CW-1:0] x_next;
        logic signed [CW-1:0] y_next;
        logic signed [ZW-1:0] z_next;

        if (k == 0)
        begin : g_first
            assign valid_in = in_valid;
            assign x_in     = in_x;
            assign y_in     = in_y;
            assign z_in     = '0;
        end
        else
        begin : g_next
            assign valid_in = valid_reg[k-1];
            assign x_in     = x_reg[k-1];
            assign y_in     = y_reg[k-1];
            assign z_in     = z_reg[k-1];
        end

        if (k < NN)
        begin : g_norm
            // greedy shift search: 32, 16, .. 1, then one last doubling
            localparam int SH  = (k < NORM_STEPS) ? (1 << (NORM_STEPS - 1 - k)) : 1;
            localparam int LOG = (k < NORM_STEPS) ? (NORM_LIMIT_LOG - SH) : NORM_LIMIT_LOG;
            localparam logic signed [CW-1:0] LIM = CW'(1) << LOG;
            logic cont;
            always_comb
            begin
                cont   = (x_in < LIM) && (y_in < LIM) && (y_in > -LIM);
                x_next = cont ? (x_in <<< SH) : x_in;
                y_next = cont ? (y_in <<< SH) : y_in;
                z_next = '0;
            end
        end
        else
        begin : g_rot
            localparam int I = k - NN;
            localparam logic signed [ZW-1:0] ANG = $signed({1'b0, atan_entry(I)});
            logic signed [CW-1:0] dx;
            logic signed [CW-1:0] dy;
            // rotate toward the x axis
            always_comb
            begin
                dx = y_in >>> I;
                dy = x_in >>> I;
                if (y_in > 0)
                begin
                    x_next = x_in + dx;
                    y_next = y_in - dy;
                    z_next = z_in + ANG;
                end
                else
                begin
                    x_next = x_in - dx;
                    y_next = y_in + dy;
                    z_next = z_in - ANG;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[k] <= x_next;
            y_reg[k] <= y_next;
            z_reg[k] <= z_next;
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_angle = z_reg[NS-1];

endmodule

FILE: tb/tb_two_link_arm_inverse_kinematics_unit.sv
// ----------------------------------------------------------------------------
// tb_two_link_arm_inverse_kinematics_unit
// Self-checking bench for the two-link arm inverse kinematics unit: a directed
// table and random targets under several link and threshold settings, each
// result word checked against a local fixed-point model of the angle math.
// ----------------------------------------------------------------------------
module tb_two_link_arm_inverse_kinematics_unit;
    import tlaik_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB       = 12;
    localparam int STAGES   = 14;
    localparam int LATENCY  = 2 * FB + STAGES + 14;
    localparam int N_RANDOM = 1350;
    localparam longint CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    tlaik_in_t   target;
    logic        done;
    tlaik_out_t  result;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    two_link_arm_inverse_kinematics_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .target    (target),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // model copy of the registers
    longint     link_upper;
    longint     link_lower;
    longint     flip_level;

    tlaik_out_t pending_angles[$];
    int         fail_count;
    longint     cycle_count;

    // arctangent table with 30 fraction bits
    function automatic longint atan_step(input int idx);
        longint tab[24];
        tab = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                16775850, 8388437, 4194282, 2097149, 1048575, 524287,
                262143, 131071, 65535, 32767, 16383, 8191,
                4095, 2047, 1023, 511, 255, 127};
        return tab[idx];
    endfunction

    // floor division by a power of two
    function automatic longint floor_shift(input longint v, input int k);
        if (v >= 0)
            return v >>> k;
        return -((-(v + 1)) >>> k) - 1;
    endfunction

    function automatic longint int_sqrt(input longint v);
        longint res;
        longint bitv;
        res  = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > v)
            bitv = bitv >>> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >>> 1) + bitv;
            end
            else
                res = res >>> 1;
            bitv = bitv >>> 2;
        end
        return res;
    endfunction

    // vectoring cordic, atan(y/x) for x >= 0
    function automatic longint vector_angle(input longint x, input longint y);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        while (x < (64'sd1 <<< 40) && y < (64'sd1 <<< 40) && y > -(64'sd1 <<< 40))
        begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_step(i);
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_step(i);
            end
        end
        return floor_shift(z + (64'sd1 <<< (29 - FB)), 30 - FB);
    endfunction

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    // joint angles for one target word
    function automatic tlaik_out_t solve_joints(input tlaik_in_t w);
        tlaik_out_t r;
        longint dd, hh, num, den, anum, one, dq, adq, sgn, s, t3, xr, yr, t2, t3o;
        logic [1:0] st;
        dd   = w.reach_distance;
        hh   = w.target_height;
        one  = 64'sd1 <<< FB;
        num  = dd * dd + hh * hh - link_upper * link_upper - link_lower * link_lower;
        den  = 2 * link_upper * link_lower;
        anum = (num < 0) ? -num : num;
        st   = ST_OK;
        r    = '0;
        if (den == 0 || dd == 0)
            st = ST_DIV0;
        else if (anum > den)
            st = ST_UNREACH;
        else if (num == 0)
            st = ST_DIV0;
        if (st == ST_OK)
        begin
            dq  = (num * one) / den;
            adq = (dq < 0) ? -dq : dq;
            sgn = (num < 0) ? -1 : 1;
            s   = int_sqrt(one * one - adq * adq);
            t3  = sgn * vector_angle(adq, s);
            xr  = link_upper * one + link_lower * adq;
            yr  = sgn * link_lower * s;
            if (xr == 0)
                st = ST_DIV0;
            else
            begin
                t2 = vector_angle(xr, yr)
                   - vector_angle((dd < 0) ? -dd : dd, (dd < 0) ? -hh : hh);
                t3o = -t3;
                if (t2 > flip_level)
                begin
                    t2  = t2 + t3o;
                    t3o = -t3o;
                end
                r.shoulder_angle = clamp16(t2);
                r.elbow_angle    = clamp16(t3o);
                return r;
            end
        end
        r.status = st;
        return r;
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        tlaik_out_t exp_w;
        if (rst_n && done)
        begin
            if (pending_angles.size() == 0)
            begin
                $error("result word with nothing expected");
                fail_count++;
            end
            else
            begin
                exp_w = pending_angles.pop_front();
                if (result.shoulder_angle !== exp_w.shoulder_angle)
                begin
                    $error("shoulder_angle exp %0d got %0d",
                           exp_w.shoulder_angle, result.shoulder_angle);
                    fail_count++;
                end
                if (result.elbow_angle !== exp_w.elbow_angle)
                begin
                    $error("elbow_angle exp %0d got %0d",
                           exp_w.elbow_angle, result.elbow_angle);
                    fail_count++;
                end
                if (result.status !== exp_w.status)
                begin
                    $error("status exp %0d got %0d", exp_w.status, result.status);
                    fail_count++;
                end
            end
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // send one target word, optionally with a typed expectation
    task automatic send_target(input logic signed [15:0] dd, input logic signed [15:0] hh,
                               input bit typed, input tlaik_out_t typed_w);
        tlaik_in_t w;
        tlaik_out_t pred;
        int g;
        w.reach_distance = dd;
        w.target_height  = hh;
        pred = solve_joints(w);
        if (typed && pred !== typed_w)
        begin
            $error("table row disagrees with model for %0d,%0d", dd, hh);
            fail_count++;
        end
        start  <= 1'b1;
        target <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_angles = {pending_angles, pred};
        g = gap_len();
        if (g > 0)
        begin
            start  <= 1'b0;
            target <= tlaik_in_t'($urandom);
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        while (pending_angles.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // write enable stays high across back-to-back writes; the caller drops it
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        start     <= 1'b0;
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_UPPER: link_upper = val[14:0];
            CFG_LOWER: link_lower = val[14:0];
            CFG_FLIP:  flip_level = longint'($signed(val));
            default:   ;
        endcase
    endtask

    // random target: mostly inside the square bounded by the full arm reach
    task automatic send_random();
        longint r;
        logic signed [15:0] dd, hh;
        r = link_upper + link_lower;
        if ($urandom_range(0, 9) < 7 && r > 0 && r < 30000)
        begin
            dd = $signed(16'($urandom_range(0, 2 * r) - r));
            hh = $signed(16'($urandom_range(0, 2 * r) - r));
        end
        else
        begin
            dd = 16'($urandom);
            hh = 16'($urandom);
        end
        send_target(dd, hh, 1'b0, '0);
    endtask

    typedef struct {
        logic signed [15:0] dd;
        logic signed [15:0] hh;
        bit                 typed;
        tlaik_out_t         w;
    } target_row_t;

    target_row_t directed_rows[$];

    initial
    begin
        longint settings[6][3];
        settings = '{'{3277, 3277, -1434}, '{32767, 32767, 32767},
                     '{0, 3277, 0}, '{1, 1, -32768},
                     '{4096, 2048, 0}, '{1200, 3000, 2000}};
        rst_n       = 1'b0;
        start       = 1'b0;
        target      = '0;
        cfg_write   = 1'b0;
        cfg_index   = CFG_UPPER;
        cfg_data    = '0;
        fail_count  = 0;
        cycle_count = 0;
        link_upper  = 3277;
        link_lower  = 3277;
        flip_level  = -1434;

        // directed rows: errors typed, the rest from the model
        directed_rows = '{
            '{16'sd0, 16'sd1000, 1'b1, '{16'sd0, 16'sd0, ST_DIV0}},
            '{16'sd0, 16'sd0, 1'b1, '{16'sd0, 16'sd0, ST_DIV0}},
            '{16'sh7fff, 16'sh7fff, 1'b1, '{16'sd0, 16'sd0, ST_UNREACH}},
            '{-16'sh8000, -16'sh8000, 1'b1, '{16'sd0, 16'sd0, ST_UNREACH}},
            '{16'sh7fff, -16'sh8000, 1'b1, '{16'sd0, 16'sd0, ST_UNREACH}},
            '{16'sd1, 16'sd0, 1'b0, '0},
            '{16'sd6554, 16'sd0, 1'b0, '0},
            '{-16'sd6554, 16'sd0, 1'b0, '0},
            '{16'sd4634, 16'sd0, 1'b0, '0},
            '{16'sd4635, 16'sd0, 1'b0, '0},
            '{16'sd3000, 16'sd3000, 1'b0, '0},
            '{-16'sd3000, 16'sd3000, 1'b0, '0},
            '{16'sd3000, -16'sd3000, 1'b0, '0},
            '{-16'sd2000, -16'sd4000, 1'b0, '0},
            '{16'sd1, 16'sd4634, 1'b0, '0},
            '{16'sd500, 16'sd100, 1'b0, '0},
            '{16'sd6000, 16'sd2000, 1'b0, '0}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_target(directed_rows[i].dd, directed_rows[i].hh,
                        directed_rows[i].typed, directed_rows[i].w);
        start <= 1'b0;
        drain_results();

        // random phases over several register settings
        for (int p = 0; p < 7; p++)
        begin
            if (p < 6)
            begin
                write_reg(CFG_UPPER, 16'(settings[p][0]));
                write_reg(CFG_LOWER, 16'(settings[p][1]));
                write_reg(CFG_FLIP, 16'(settings[p][2]));
            end
            else
            begin
                write_reg(CFG_UPPER, 16'($urandom_range(0, 32767)));
                write_reg(CFG_LOWER, 16'($urandom_range(0, 32767)));
                write_reg(CFG_FLIP, 16'($urandom));
            end
            cfg_write <= 1'b0;
            for (int n = 0; n < N_RANDOM / 7; n++)
                send_random();
            start <= 1'b0;
            drain_results();
        end

        if (fail_count == 0 && pending_angles.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
